@@ rtl/htlr_pkg.sv @@
// ----------------------------------------------------------------------------
// htlr_pkg: shared types and constants of the line retention core
// Request and result structs, policy and result kind codes, store sizes.
// ----------------------------------------------------------------------------
package htlr_pkg;

   localparam int HEAD_DEPTH     = 16;
   localparam int TAIL_DEPTH     = 16;
   localparam int MAX_LINE_BYTES = 4095;
   localparam int TAG_WIDTH      = 16;
   localparam int LEN_WIDTH      = 12;
   localparam int HEAD_AW        = $clog2(HEAD_DEPTH);
   localparam int TAIL_AW        = $clog2(TAIL_DEPTH);
   localparam int HEAD_CW        = $clog2(HEAD_DEPTH + 1);
   localparam int TAIL_CW        = $clog2(TAIL_DEPTH + 1);
   localparam int CAP_W          = 20;
   localparam int HTOT_W         = 16;
   localparam int TTOT_W         = 17;
   localparam int CSR_IDX_W      = 3;

   localparam logic [2:0] POL_ALL       = 3'd0;
   localparam logic [2:0] POL_HEAD      = 3'd2;
   localparam logic [2:0] POL_TAIL      = 3'd3;
   localparam logic [2:0] POL_HEAD_TAIL = 3'd4;

   localparam logic [2:0] KIND_HEAD    = 3'd0;
   localparam logic [2:0] KIND_TAIL    = 3'd1;
   localparam logic [2:0] KIND_DROP    = 3'd2;
   localparam logic [2:0] KIND_EVICT   = 3'd3;
   localparam logic [2:0] KIND_READOUT = 3'd4;
   localparam logic [2:0] KIND_NONE    = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_POLICY    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAD_LINE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAD_BYTE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TAIL_LINE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TAIL_BYTE = 3'd4;

   typedef struct packed {
      logic                 mode;
      logic [TAG_WIDTH-1:0] line_tag;
      logic [LEN_WIDTH-1:0] line_length;
   } req_type;

   typedef struct packed {
      logic [2:0]           kind;
      logic [TAG_WIDTH-1:0] out_tag;
      logic [LEN_WIDTH-1:0] out_length;
      logic                 last;
   } rsp_type;

   typedef struct packed {
      logic [TAG_WIDTH-1:0] tag;
      logic [LEN_WIDTH-1:0] len;
   } line_type;

endpackage

@@ rtl/htlr_store.sv @@
// ----------------------------------------------------------------------------
// htlr_store: line store RAM
// One write port, one read port; read data is registered and appears in the cycle after the address.
// ----------------------------------------------------------------------------
module htlr_store #(
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  htlr_pkg::line_type               wr_data,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output htlr_pkg::line_type               rd_data
);
   import htlr_pkg::*;

   line_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ rtl/head_tail_line_retention_core.sv @@
// ----------------------------------------------------------------------------
// head_tail_line_retention_core: bounded head/tail line buffer
// Keeps offered lines in a head store and a circular tail store under a
// configured policy, with line-count and byte caps on each store.
// ----------------------------------------------------------------------------
// Usage: a request with mode 0 offers one line (tag, length); the block
// answers with one status result, then one eviction result per tail line
// pushed out, oldest first. A request with mode 1 reads out the head lines,
// then the tail lines oldest first, and empties both stores; with nothing held
// it answers with one "nothing retained" result. last marks the final result.
// Requests are handled one at a time: req_ready is high only when the engine
// is idle. An add that goes to the head or is dropped outright ends in the
// decide state; one that goes through the tail path then reads and sends out
// the oldest tail line for each eviction before the line is appended.
// A readout fetches each retained line from its RAM before sending it.
// Results leave through one output register; while the receiver stalls the
// engine holds. Configuration writes through the csr_ port take effect on the
// next edge. Reset (synchronous) empties both stores, clears counters and
// totals and restores the register defaults. The RAMs need no clearing pass.
// ----------------------------------------------------------------------------
module head_tail_line_retention_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  htlr_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output htlr_pkg::rsp_type            rsp_data,
   input  logic                         csr_write,
   input  logic [htlr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [htlr_pkg::CAP_W-1:0]   csr_wdata
);
   import htlr_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECIDE = 3'd1;
   localparam logic [2:0] ST_EVRD  = 3'd2;
   localparam logic [2:0] ST_EVOUT = 3'd3;
   localparam logic [2:0] ST_RDH   = 3'd4;
   localparam logic [2:0] ST_RDT   = 3'd5;
   localparam logic [2:0] ST_RDOUT = 3'd6;

   logic [2:0]        policy_ff;
   logic [4:0]        hcap_ff, tcap_ff;
   logic [CAP_W-1:0]  hbcap_ff, tbcap_ff;
   logic [HEAD_CW-1:0] hcount_ff;
   logic [TAIL_CW-1:0] tcount_ff;
   logic [TAIL_AW-1:0] toldest_ff;
   logic [HTOT_W-1:0] htot_ff;
   logic [TTOT_W-1:0] ttot_ff;
   logic              hclosed_ff;
   logic [2:0]        state_ff;
   req_type           req_ff;
   logic              evall_ff;    // drop path: evict everything
   logic              append_ff;   // append the line once evictions end
   logic [HEAD_CW-1:0] ridx_ff;    // readout position
   logic              rdtail_ff;   // readout word came from the tail
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   line_type h_wdata, t_wdata, h_rdata, t_rdata;
   logic h_we, t_we;
   logic [HEAD_AW-1:0] h_waddr, h_raddr;
   logic [TAIL_AW-1:0] t_waddr, t_raddr;

   htlr_store #(.DEPTH(HEAD_DEPTH)) u_head (
      .clock(clock), .wr_en(h_we), .wr_addr(h_waddr), .wr_data(h_wdata),
      .rd_addr(h_raddr), .rd_data(h_rdata));
   htlr_store #(.DEPTH(TAIL_DEPTH)) u_tail (
      .clock(clock), .wr_en(t_we), .wr_addr(t_waddr), .wr_data(t_wdata),
      .rd_addr(t_raddr), .rd_data(t_rdata));

   // effective line caps
   logic [TAIL_CW-1:0] tlc;
   logic [HEAD_CW-1:0] hlc;
   always_comb begin
      hlc = (32'(hcap_ff) < HEAD_DEPTH) ? HEAD_CW'(hcap_ff) : HEAD_CW'(HEAD_DEPTH);
      tlc = (32'(tcap_ff) < TAIL_DEPTH) ? TAIL_CW'(tcap_ff) : TAIL_CW'(TAIL_DEPTH);
   end

   logic out_free;
   logic rsp_load;
   logic rsp_valid_in;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a result enters the output register in these states
   assign rsp_load = out_free && ((state_ff == ST_DECIDE) || (state_ff == ST_EVOUT) ||
                     (state_ff == ST_RDOUT) ||
                     ((state_ff == ST_RDT) && (hcount_ff == '0) && (tcount_ff == '0)));
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   // decide-stage terms
   logic [CAP_W:0] head_sum, tail_sum;
   logic head_fits, tail_fits, need_evict;
   logic [TAIL_AW-1:0] tail_slot;
   always_comb begin
      head_sum  = (CAP_W+1)'(htot_ff) + (CAP_W+1)'(req_ff.line_length);
      tail_sum  = (CAP_W+1)'(ttot_ff) + (CAP_W+1)'(req_ff.line_length);
      head_fits = !hclosed_ff && (hcount_ff < hlc) && (head_sum <= (CAP_W+1)'(hbcap_ff));
      tail_fits = (tlc != '0) && ((CAP_W)'(req_ff.line_length) <= tbcap_ff);
      need_evict = (tcount_ff != '0) && ((tcount_ff >= tlc) ||
                   (tail_sum > (CAP_W+1)'(tbcap_ff)));
      tail_slot = TAIL_AW'(32'(toldest_ff) + 32'(tcount_ff));
   end

   logic [TAIL_AW-1:0] rd_slot;
   always_comb begin
      rd_slot = TAIL_AW'(32'(toldest_ff) + 32'(ridx_ff));
      h_raddr = HEAD_AW'(ridx_ff);
      // hold the tail read address while a tail readout word waits
      t_raddr = ((state_ff == ST_RDT) || (state_ff == ST_RDOUT && rdtail_ff)) ?
                rd_slot : toldest_ff;
      h_we    = 1'b0;
      t_we    = 1'b0;
      h_waddr = HEAD_AW'(hcount_ff);
      t_waddr = tail_slot;
      h_wdata = '{tag: req_ff.line_tag, len: req_ff.line_length};
      t_wdata = h_wdata;
      if (state_ff == ST_DECIDE && out_free && !req_ff.mode &&
          32'(req_ff.line_length) <= MAX_LINE_BYTES) begin
         unique case (policy_ff)
            POL_ALL:       h_we = (32'(hcount_ff) < HEAD_DEPTH);
            POL_HEAD,
            POL_HEAD_TAIL: h_we = head_fits;
            default:       h_we = 1'b0;
         endcase
      end
      if (state_ff == ST_EVRD && append_ff && !need_evict) begin
         t_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff    <= POL_ALL;
         hcap_ff      <= 5'd16;
         tcap_ff      <= 5'd16;
         hbcap_ff     <= '1;
         tbcap_ff     <= '1;
         hcount_ff    <= '0;
         tcount_ff    <= '0;
         toldest_ff   <= '0;
         htot_ff      <= '0;
         ttot_ff      <= '0;
         hclosed_ff   <= 1'b0;
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         evall_ff     <= 1'b0;
         append_ff    <= 1'b0;
         ridx_ff      <= '0;
         rdtail_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_POLICY:    policy_ff <= csr_wdata[2:0];
               CSR_HEAD_LINE: hcap_ff   <= csr_wdata[4:0];
               CSR_HEAD_BYTE: hbcap_ff  <= csr_wdata;
               CSR_TAIL_LINE: tcap_ff   <= csr_wdata[4:0];
               CSR_TAIL_BYTE: tbcap_ff  <= csr_wdata;
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  req_ff   <= req_data;
                  ridx_ff  <= '0;
                  state_ff <= req_data.mode ? ST_RDH : ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               if (out_free) begin
                  logic [2:0] k;
                  logic go_tail;
                  k = KIND_DROP;
                  go_tail = 1'b0;
                  if (32'(req_ff.line_length) <= MAX_LINE_BYTES) begin
                     unique case (policy_ff)
                        POL_ALL: if (32'(hcount_ff) < HEAD_DEPTH) k = KIND_HEAD;
                        POL_HEAD: begin
                           if (head_fits) k = KIND_HEAD;
                           else hclosed_ff <= 1'b1;
                        end
                        POL_TAIL: go_tail = 1'b1;
                        POL_HEAD_TAIL: begin
                           if (head_fits) k = KIND_HEAD;
                           else begin
                              hclosed_ff <= 1'b1;
                              go_tail = 1'b1;
                           end
                        end
                        default: k = KIND_DROP;
                     endcase
                  end
                  if (go_tail) k = tail_fits ? KIND_TAIL : KIND_DROP;
                  if (k == KIND_HEAD) begin
                     hcount_ff <= hcount_ff + HEAD_CW'(1);
                     htot_ff   <= HTOT_W'(32'(htot_ff) + 32'(req_ff.line_length));
                  end
                  evall_ff  <= go_tail && !tail_fits;
                  append_ff <= go_tail && tail_fits;
                  rsp_ff <= '{kind: k, out_tag: req_ff.line_tag,
                              out_length: req_ff.line_length,
                              last: !(go_tail && (tcount_ff != '0) &&
                                      (!tail_fits || need_evict))};
                  state_ff <= go_tail ? ST_EVRD : ST_IDLE;
               end
            end
            ST_EVRD: begin
               // tail RAM is reading the oldest slot this cycle
               if ((evall_ff && tcount_ff != '0) || (append_ff && need_evict)) begin
                  state_ff <= ST_EVOUT;
               end else begin
                  if (append_ff) begin
                     tcount_ff <= tcount_ff + TAIL_CW'(1);
                     ttot_ff   <= TTOT_W'(32'(ttot_ff) + 32'(req_ff.line_length));
                  end
                  state_ff <= ST_IDLE;
               end
            end
            ST_EVOUT: begin
               if (out_free) begin
                  logic more;
                  logic [TAIL_CW-1:0] nc;
                  logic [TTOT_W-1:0]  nt;
                  nc = tcount_ff - TAIL_CW'(1);
                  nt = ttot_ff - TTOT_W'(t_rdata.len);
                  more = evall_ff ? (nc != '0) :
                         ((nc != '0) && ((nc >= tlc) ||
                          ((CAP_W+1)'(nt) + (CAP_W+1)'(req_ff.line_length) >
                           (CAP_W+1)'(tbcap_ff))));
                  tcount_ff  <= nc;
                  ttot_ff    <= nt;
                  toldest_ff <= TAIL_AW'(32'(toldest_ff) + 1);
                  rsp_ff <= '{kind: KIND_EVICT, out_tag: t_rdata.tag,
                              out_length: t_rdata.len, last: !more};
                  state_ff <= ST_EVRD;
               end
            end
            ST_RDH: begin
               if (ridx_ff < hcount_ff) begin
                  rdtail_ff <= 1'b0;
                  state_ff  <= ST_RDOUT;
               end else begin
                  ridx_ff  <= '0;
                  state_ff <= ST_RDT;
               end
            end
            ST_RDT: begin
               if (32'(ridx_ff) < 32'(tcount_ff)) begin
                  rdtail_ff <= 1'b1;
                  state_ff  <= ST_RDOUT;
               end else if (out_free) begin
                  if (hcount_ff == '0 && tcount_ff == '0) begin
                     rsp_ff <= '{kind: KIND_NONE, out_tag: '0, out_length: '0,
                                 last: 1'b1};
                  end
                  hcount_ff  <= '0;
                  tcount_ff  <= '0;
                  toldest_ff <= '0;
                  htot_ff    <= '0;
                  ttot_ff    <= '0;
                  hclosed_ff <= 1'b0;
                  state_ff   <= ST_IDLE;
               end
            end
            ST_RDOUT: begin
               if (out_free) begin
                  line_type w;
                  logic [HEAD_CW-1:0] ni;
                  logic lst;
                  w  = rdtail_ff ? t_rdata : h_rdata;
                  ni = ridx_ff + HEAD_CW'(1);
                  lst = rdtail_ff ? (32'(ni) >= 32'(tcount_ff)) :
                        ((ni >= hcount_ff) && (tcount_ff == '0));
                  rsp_ff <= '{kind: KIND_READOUT, out_tag: w.tag,
                              out_length: w.len, last: lst};
                  if (!rdtail_ff && ni >= hcount_ff) begin
                     ridx_ff  <= '0;
                     state_ff <= ST_RDT;
                  end else begin
                     ridx_ff  <= ni;
                     state_ff <= rdtail_ff ? ST_RDT : ST_RDH;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
